[hdl/bced_pkg.sv]
package bced_pkg;

  // Tick counter width; counters saturate at all ones.
  localparam int COUNT_BITS = 16;
  // Width of the threshold registers.
  localparam int TICK_BITS = 16;
  // Common width for counter against threshold compares.
  localparam int CMP_BITS = (COUNT_BITS > TICK_BITS) ? COUNT_BITS : TICK_BITS;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CLICK_BITS = 2;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [TICK_BITS-1:0]  tick_t;
  typedef logic [CMP_BITS-1:0]   cmp_t;
  typedef logic [CLICK_BITS-1:0] click_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } ev_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_LONG_PRESS = 2'd0,
    REG_GAP        = 2'd1
  } reg_idx_t;

  localparam count_t COUNT_MAX  = '1;
  localparam click_t CLICKS_MAX = '1;
  localparam click_t ONE_CLICK  = click_t'(1);
  localparam click_t TWO_CLICKS = click_t'(2);

  localparam tick_t LONG_PRESS_RESET = tick_t'(100);
  localparam tick_t GAP_RESET        = tick_t'(30);

  function automatic count_t sat_inc(input count_t v);
    return (v == COUNT_MAX) ? v : count_t'(v + count_t'(1));
  endfunction

endpackage

[hdl/button_click_event_detector_unit.sv]
// Channel  | direction | handshake          | payload
// -------- | --------- | ------------------ | -------------------------------------
// in       | to block  | in_valid/in_stall  | pin_level, take_event (one scan tick)
// out      | from blk  | out_valid/out_stall| raised_event, taken_event
// cfg      | to block  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item per cycle while in_stall is low; its result shows in the output
// register in the cycle after acceptance. The state update and result are one
// pass of counter, compare and select logic in front of that register.
// rst is synchronous, active high: counters, click count and latch clear,
// thresholds return to 100 and 30 ticks.
// in_stall rises only while the output register holds an item that out_stall
// keeps; a result taken in the same cycle frees the slot for the next item.
// cfg_ready is always high; index values past the register list are dropped.
module button_click_event_detector_unit
  import bced_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  // scan tick input
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      pin_level,
  input  logic                      take_event,
  // results
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                raised_event,
  output logic [1:0]                taken_event,
  // register writes
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [TICK_BITS-1:0]      cfg_data
);

  // Threshold registers
  tick_t long_press_ticks;
  tick_t double_click_gap_ticks;

  // Detector state
  count_t held_ticks, held_ticks_next;
  count_t released_ticks, released_ticks_next;
  click_t clicks_seen, clicks_seen_next;
  logic   long_reported, long_reported_next;
  ev_t    pending_event, pending_event_next;

  ev_t    raised, taken;
  logic   in_acc;

  // Output slot is free unless a result waits and is being held back.
  assign in_stall  = out_valid && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks       <= LONG_PRESS_RESET;
      double_click_gap_ticks <= GAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LONG_PRESS: long_press_ticks       <= cfg_data;
        REG_GAP:        double_click_gap_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // One scan tick: count, classify the press, decide clicks, update latch.
  always_comb begin
    cmp_t held_w, rel_w, lp_w, gap_w;
    held_ticks_next     = held_ticks;
    released_ticks_next = released_ticks;
    clicks_seen_next    = clicks_seen;
    long_reported_next  = long_reported;
    pending_event_next  = pending_event;
    raised              = EV_NONE;
    taken               = EV_NONE;
    lp_w                = cmp_t'(long_press_ticks);
    gap_w               = cmp_t'(double_click_gap_ticks);

    if (!pin_level) begin
      // pressed
      held_ticks_next     = sat_inc(held_ticks);
      released_ticks_next = '0;
      held_w              = cmp_t'(held_ticks_next);
      if (held_w >= lp_w && !long_reported) begin
        raised             = EV_LONG;
        long_reported_next = 1'b1;
        clicks_seen_next   = '0;
      end
    end else begin
      // released: a short press that just ended counts as a click
      released_ticks_next = sat_inc(released_ticks);
      held_w              = cmp_t'(held_ticks);
      if (!long_reported && held_ticks != '0 && held_w < lp_w &&
          clicks_seen != CLICKS_MAX) begin
        clicks_seen_next = click_t'(clicks_seen + ONE_CLICK);
      end
      held_ticks_next    = '0;
      long_reported_next = 1'b0;
    end

    rel_w = cmp_t'(released_ticks_next);
    if (clicks_seen_next == ONE_CLICK && rel_w >= gap_w) begin
      raised              = EV_SINGLE;
      clicks_seen_next    = '0;
      released_ticks_next = '0;
    end else if (clicks_seen_next == TWO_CLICKS) begin
      raised              = EV_DOUBLE;
      clicks_seen_next    = '0;
      released_ticks_next = '0;
    end

    if (raised != EV_NONE) begin
      pending_event_next = raised;
    end
    if (take_event) begin
      taken              = pending_event_next;
      pending_event_next = EV_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_ticks     <= '0;
      released_ticks <= '0;
      clicks_seen    <= '0;
      long_reported  <= 1'b0;
      pending_event  <= EV_NONE;
    end else if (in_acc) begin
      held_ticks     <= held_ticks_next;
      released_ticks <= released_ticks_next;
      clicks_seen    <= clicks_seen_next;
      long_reported  <= long_reported_next;
      pending_event  <= pending_event_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      raised_event <= raised;
      taken_event  <= taken;
    end
  end

`ifndef SYNTH
  // Two clicks resolve in the same tick, so the stored count never reaches two.
  a_clicks_below_two: assert property (@(posedge clk) disable iff (rst)
    clicks_seen == '0 || clicks_seen == ONE_CLICK)
    else $error("clicks_seen holds a resolved count");

  // A long press is only on record while the key is held.
  a_long_needs_hold: assert property (@(posedge clk) disable iff (rst)
    long_reported |-> held_ticks != '0)
    else $error("long_reported set with no hold");

  // A take always leaves the latch empty.
  a_take_clears: assert property (@(posedge clk) disable iff (rst)
    in_acc && take_event |=> pending_event == EV_NONE)
    else $error("latch not cleared after take");

  // Every accepted tick lands in the result register.
  a_acc_fills_out: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> out_valid)
    else $error("accepted tick produced no result");
`endif

endmodule

[tb/sv/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bced_pkg::*;

  // Spare register indexes past the end of the list; writes to them must be dropped.
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 2'd3;

  // Watchdog. The slowest legal run stays well under the limit: about 1300 items,
  // each with a random idle gap and receiver stall, plus one long hold-off and the drains.
  localparam int unsigned CYCLE_LIMIT = 100_000;
  localparam int unsigned LONG_HOLD = 40;
  localparam int unsigned ITEMS_PER_PHASE = 140;
  localparam int unsigned PHASES = 6;
  localparam int unsigned FINAL_RUN = 40;

  // One scan result as the output port shows it.
  typedef struct packed {
    ev_t raised;
    ev_t taken;
  } scan_result_t;

  // One row of the directed script: a tick pattern repeated reps times. Where
  // typed is set, the result is written into the row; else the predictor gives it.
  typedef struct packed {
    logic        pin;
    logic        take;
    int unsigned reps;
    logic        typed;
    ev_t         raised;
    ev_t         taken;
  } scan_row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      pin_level = 1'b1;
  logic                      take_event = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [1:0]                raised_event;
  logic [1:0]                taken_event;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_LONG_PRESS;
  logic [TICK_BITS-1:0]      cfg_data = '0;

  button_click_event_detector_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pin_level    (pin_level),
    .take_event   (take_event),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .raised_event (raised_event),
    .taken_event  (taken_event),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the thresholds and of the detector state.
  // ---------------------------------------------------------------------------
  tick_t  long_limit = LONG_PRESS_RESET;
  tick_t  gap_limit  = GAP_RESET;
  count_t held_run   = '0;   // ticks held in the current press, saturating
  count_t quiet_run  = '0;   // ticks released since the last press, saturating
  click_t click_tally = '0;
  logic   long_seen  = 1'b0; // long press already raised in this hold
  ev_t    latched_ev = EV_NONE;

  scan_result_t expected_events [$];
  scan_result_t head;
  int unsigned  mismatches = 0;

  logic quiet = 1'b0;    // no idling on either side
  logic hold_req = 1'b0; // ask the receiver for one long hold-off

  scan_row_t script [0:16];

  // One scan tick through the detector; updates the predictor state.
  function automatic void scan_tick(input logic pin, input logic take,
                                    output ev_t raised, output ev_t taken);
    raised = EV_NONE;
    taken  = EV_NONE;
    if (!pin) begin
      // pressed: count up the hold, release count restarts
      if (held_run != COUNT_MAX) held_run = held_run + count_t'(1);
      quiet_run = '0;
      if (held_run >= long_limit && !long_seen) begin
        raised      = EV_LONG;
        long_seen   = 1'b1;
        click_tally = '0;
      end
    end else begin
      if (quiet_run != COUNT_MAX) quiet_run = quiet_run + count_t'(1);
      // a press shorter than the long threshold turns into a click on release
      if (!long_seen && held_run != '0 && held_run < long_limit &&
          click_tally != CLICKS_MAX)
        click_tally = click_tally + click_t'(1);
      held_run  = '0;
      long_seen = 1'b0;
    end

    if (click_tally == ONE_CLICK && quiet_run >= gap_limit) begin
      raised      = EV_SINGLE;
      click_tally = '0;
      quiet_run   = '0;
    end else if (click_tally == TWO_CLICKS) begin
      raised      = EV_DOUBLE;
      click_tally = '0;
      quiet_run   = '0;
    end

    if (raised != EV_NONE) latched_ev = raised;
    // take in the same tick sees the event raised in it
    if (take) begin
      taken      = latched_ev;
      latched_ev = EV_NONE;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset and watchdog
  // ---------------------------------------------------------------------------
  initial begin
    forever #1 clk = ~clk;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("button_click_event_detector_unit verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: after each accepted result, stall at random or not at all, or for one
  // long stretch on request so that the output slot fills and in_stall rises.
  // ---------------------------------------------------------------------------
  initial begin : sink
    int unsigned hold;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        hold = quiet ? 0 : $urandom_range(0, 4);
        if (hold_req) begin
          hold_req = 1'b0;
          hold     = LONG_HOLD;
        end
        if (hold != 0) begin
          @(negedge clk);
          out_stall <= 1'b1;
          repeat (hold) @(negedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected item, raised_event %0d taken_event %0d",
                 $time, raised_event, taken_event);
        mismatches++;
      end else begin
        head = expected_events.pop_front();
        if (raised_event !== head.raised) begin
          $display("%0t: raised_event expected %0d got %0d",
                   $time, head.raised, raised_event);
          mismatches++;
        end
        if (taken_event !== head.taken) begin
          $display("%0t: taken_event expected %0d got %0d",
                   $time, head.taken, taken_event);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender tasks. All are entered and left at a falling edge.
  // ---------------------------------------------------------------------------

  // Offer one scan tick after a random idle gap; on acceptance, queue its result.
  task automatic send_tick(input logic pin, input logic take, input logic typed,
                           input ev_t want_raised, input ev_t want_taken);
    int unsigned  idle;
    scan_result_t res;
    idle = quiet ? 0 : $urandom_range(0, 4);
    if (idle != 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_valid   <= 1'b1;
    pin_level  <= pin;
    take_event <= take;
    do @(posedge clk); while (in_stall);
    scan_tick(pin, take, res.raised, res.taken);
    if (typed) begin
      res.raised = want_raised;
      res.taken  = want_taken;
    end
    expected_events.push_back(res);
    @(negedge clk);
  endtask

  // Stop offering and wait until every queued result has come out.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Register write; only called with the block drained.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input tick_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_LONG_PRESS)
      long_limit = value;
    else if (idx == REG_GAP)
      gap_limit = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Random press/release runs sized around the thresholds, with some noise ticks.
  task automatic run_phase(input int unsigned count);
    int unsigned sent;
    int unsigned press_top;
    int unsigned rel_top;
    int unsigned press_len;
    int unsigned rel_len;
    sent      = 0;
    press_top = (long_limit > 150) ? 150 : int'(long_limit) + 2;
    rel_top   = (gap_limit > 150) ? 150 : int'(gap_limit) + 3;
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) begin
        send_tick(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0,
                  1'b0, EV_NONE, EV_NONE);
        sent++;
      end else begin
        press_len = $urandom_range(1, press_top);
        rel_len   = $urandom_range(1, rel_top);
        repeat (press_len)
          send_tick(1'b0, $urandom_range(0, 3) == 0, 1'b0, EV_NONE, EV_NONE);
        repeat (rel_len)
          send_tick(1'b1, $urandom_range(0, 3) == 0, 1'b0, EV_NONE, EV_NONE);
        sent += press_len + rel_len;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    // Directed script, run at the reset thresholds (long 100, gap 30).
    script = '{
      // idle tick straight after reset: nothing raised, nothing latched
      '{1'b1, 1'b1, 1,  1'b1, EV_NONE, EV_NONE},
      // one click, then the gap runs out: single, taken in the same tick
      '{1'b0, 1'b0, 1,  1'b0, EV_NONE, EV_NONE},
      '{1'b1, 1'b0, 1,  1'b0, EV_NONE, EV_NONE},
      '{1'b1, 1'b0, 28, 1'b0, EV_NONE, EV_NONE},
      '{1'b1, 1'b1, 1,  1'b0, EV_NONE, EV_NONE},
      // two quick clicks: double
      '{1'b0, 1'b0, 1,  1'b0, EV_NONE, EV_NONE},
      '{1'b1, 1'b0, 1,  1'b0, EV_NONE, EV_NONE},
      '{1'b0, 1'b0, 1,  1'b0, EV_NONE, EV_NONE},
      '{1'b1, 1'b1, 1,  1'b0, EV_NONE, EV_NONE},
      // hold to exactly the long threshold, then take the long press
      '{1'b0, 1'b0, 99, 1'b0, EV_NONE, EV_NONE},
      '{1'b0, 1'b0, 1,  1'b1, EV_LONG, EV_NONE},
      '{1'b0, 1'b1, 1,  1'b1, EV_NONE, EV_LONG},
      '{1'b1, 1'b1, 1,  1'b1, EV_NONE, EV_NONE},
      // click pending, then a long press drops it
      '{1'b0, 1'b0, 5,  1'b0, EV_NONE, EV_NONE},
      '{1'b1, 1'b0, 1,  1'b0, EV_NONE, EV_NONE},
      '{1'b0, 1'b0, 100, 1'b0, EV_NONE, EV_NONE},
      '{1'b1, 1'b1, 40, 1'b0, EV_NONE, EV_NONE}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (script[r])
      repeat (script[r].reps)
        send_tick(script[r].pin, script[r].take, script[r].typed,
                  script[r].raised, script[r].taken);

    // Random phases: thresholds of one, then zero (plus spare-index writes), then small random.
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      if (ph == 0) begin
        write_reg(REG_LONG_PRESS, tick_t'(1));
        write_reg(REG_GAP, tick_t'(1));
      end else if (ph == 1) begin
        // zero long threshold: no clicks; zero gap: single decided at once
        write_reg(REG_LONG_PRESS, '0);
        write_reg(REG_GAP, '0);
        write_reg(REG_SPARE_LO, tick_t'($urandom));
        write_reg(REG_SPARE_HI, '1);
      end else begin
        write_reg(REG_LONG_PRESS, tick_t'($urandom_range(2, 12)));
        write_reg(REG_GAP, tick_t'($urandom_range(1, 10)));
      end
      if (ph == 2) hold_req = 1'b1;
      run_phase(ITEMS_PER_PHASE);
    end

    // Largest thresholds with back-to-back ticks: neither limit is reached, so a
    // long hold still ends as a click and the next click makes a double.
    drain();
    quiet = 1'b1;
    write_reg(REG_LONG_PRESS, '1);
    write_reg(REG_GAP, '1);
    repeat (FINAL_RUN)
      send_tick(1'b0, $urandom_range(0, 7) == 0, 1'b0, EV_NONE, EV_NONE);
    repeat (FINAL_RUN)
      send_tick(1'b1, $urandom_range(0, 7) == 0, 1'b0, EV_NONE, EV_NONE);
    send_tick(1'b0, 1'b0, 1'b0, EV_NONE, EV_NONE);
    repeat (FINAL_RUN)
      send_tick(1'b1, $urandom_range(0, 7) == 0, 1'b0, EV_NONE, EV_NONE);

    drain();
    if (mismatches == 0)
      $display("button_click_event_detector_unit verification clean");
    else
      $display("button_click_event_detector_unit verification failed");
    $finish;
  end

endmodule

[sim.f]
hdl/bced_pkg.sv
hdl/button_click_event_detector_unit.sv
tb/sv/testbench.sv
